[sv/graph_connectivity_matrix_assert.svh]
// ----------------------------------------------------------------------------
// Graph connectivity matrix assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_CONNECTIVITY_MATRIX_ASSERT_SVH
`define GRAPH_CONNECTIVITY_MATRIX_ASSERT_SVH

// same-cycle implication
`define GCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gcm assertion failed");

// next-cycle implication
`define GCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gcm assertion failed");

`endif

[sv/gcm_pkg.sv]
// ----------------------------------------------------------------------------
// gcm_pkg
// Types and constants shared by the connectivity matrix modules.
// ----------------------------------------------------------------------------
package gcm_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = 4;
	localparam int VCNT_W       = 5;

	localparam logic [VCNT_W-1:0] VCOUNT_RESET = 5'd16;

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_REPORT   = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [VIDX_W-1:0] src_vertex;
		logic [VIDX_W-1:0] dst_vertex;
	} in_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0]       row_vertex;
		logic [MAX_VERTICES-1:0] row_bits;
		logic                    last_row;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic edge_wr;   // store the edge in the input request
		logic start;     // first row of a report
		logic step;      // expand one pending vertex
		logic capture;   // load the finished row into the output register
		logic next_row;  // advance to the following row
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pending_empty;
		logic last;
		logic count_zero;
	} dp_status_t;

endpackage

[sv/gcm_ctrl.sv]
// ----------------------------------------------------------------------------
// gcm_ctrl
// Sequencer: takes requests, runs one search per row, hands rows out.
// ----------------------------------------------------------------------------
module gcm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	input  gcm_pkg::dp_status_t status,
	output gcm_pkg::dp_cmd_t    dp_cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_EMIT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_cmd == gcm_pkg::CMD_ADD_EDGE) begin
						dp_cmd.edge_wr = 1'b1;
					end else if (!status.count_zero) begin
						dp_cmd.start = 1'b1;
						state_d      = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (status.pending_empty) begin
					dp_cmd.capture = 1'b1;
					state_d        = S_EMIT;
				end else begin
					dp_cmd.step = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_ready) begin
					if (status.last) begin
						state_d = S_IDLE;
					end else begin
						dp_cmd.next_row = 1'b1;
						state_d         = S_SEARCH;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/gcm_datapath.sv]
// ----------------------------------------------------------------------------
// gcm_datapath
// Adjacency matrix, vertex count, search sets and the output register.
// ----------------------------------------------------------------------------
module gcm_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [gcm_pkg::VCNT_W-1:0]         cfg_data,
	input  gcm_pkg::in_item_t                  in_data,
	input  gcm_pkg::dp_cmd_t                   dp_cmd,
	output gcm_pkg::dp_status_t                status,
	output gcm_pkg::out_item_t                 out_data
);

	localparam int NV = gcm_pkg::MAX_VERTICES;
	localparam int VW = gcm_pkg::VIDX_W;
	localparam int CW = gcm_pkg::VCNT_W;

	logic [CW-1:0] vcount_q;
	logic [CW-1:0] n_eff;
	logic [NV:0]   mask_ext;
	logic [NV-1:0] mask;

	logic [NV-1:0] adj_q [NV];
	logic [NV-1:0] visited_q;
	logic [NV-1:0] pending_q;
	logic [VW-1:0] row_q;

	logic [VW-1:0] v_sel;
	logic [NV-1:0] fresh;
	logic          edge_ok;
	logic [VW-1:0] row_inc;
	gcm_pkg::out_item_t out_q;

	// counts above the matrix size saturate
	assign n_eff    = (vcount_q > CW'(NV)) ? CW'(NV) : vcount_q;
	assign mask_ext = ((NV+1)'(1) << n_eff) - (NV+1)'(1);
	assign mask     = mask_ext[NV-1:0];

	assign edge_ok = (in_data.src_vertex != in_data.dst_vertex)
		&& ({1'b0, in_data.src_vertex} < n_eff)
		&& ({1'b0, in_data.dst_vertex} < n_eff);

	// lowest pending vertex is expanded next
	always_comb begin
		v_sel = '0;
		for (int k = NV - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				v_sel = VW'(k);
			end
		end
	end

	assign fresh   = adj_q[v_sel] & mask & ~visited_q;
	assign row_inc = row_q + VW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gcm_pkg::VCOUNT_RESET;
			for (int r = 0; r < NV; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				vcount_q <= cfg_data;
			end
			if (dp_cmd.edge_wr && edge_ok) begin
				adj_q[in_data.src_vertex][in_data.dst_vertex] <= 1'b1;
				adj_q[in_data.dst_vertex][in_data.src_vertex] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			row_q     <= '0;
			visited_q <= NV'(1);
			pending_q <= NV'(1);
		end else if (dp_cmd.next_row) begin
			row_q     <= row_inc;
			visited_q <= NV'(1) << row_inc;
			pending_q <= NV'(1) << row_inc;
		end else if (dp_cmd.step) begin
			visited_q <= visited_q | fresh;
			pending_q <= (pending_q & ~(NV'(1) << v_sel)) | fresh;
		end
		if (dp_cmd.capture) begin
			out_q.row_vertex <= row_q;
			out_q.row_bits   <= visited_q & mask & ~(NV'(1) << row_q);
			out_q.last_row   <= status.last;
		end
	end

	assign status.pending_empty = (pending_q == '0);
	assign status.last          = ((CW'(row_q) + CW'(1)) == n_eff);
	assign status.count_zero    = (n_eff == '0);
	assign out_data             = out_q;

endmodule

[sv/graph_connectivity_matrix.sv]
// Edge request: accepted while the block is idle; the block stays idle and ready.
// Report: per row i, the search expands each vertex of i's component in
// turn, then loads the output register, then hands the row out, holding it
// while out_ready is low.
// One request at a time; set by the single-vertex-per-cycle search loop.
// Reset: matrix cleared, vertex_count = 16, block idle and ready.
// ----------------------------------------------------------------------------
// graph_connectivity_matrix
// Undirected adjacency bit matrix with per-vertex connectivity report.
// ----------------------------------------------------------------------------
module graph_connectivity_matrix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [gcm_pkg::VCNT_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  gcm_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gcm_pkg::out_item_t         out_data
);

	gcm_pkg::dp_cmd_t    dp_cmd;
	gcm_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	gcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	gcm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.dp_cmd    (dp_cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

[sv/gcm_checker.sv]
// ----------------------------------------------------------------------------
// gcm_port_checker
// Port-level checks for the connectivity matrix, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_connectivity_matrix_assert.svh"

module gcm_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input gcm_pkg::out_item_t out_data
);

	`GCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// no new request while a report still has rows to give
	`GCM_ASSERT_NOW(a_busy_when_out, clk, arst_n, out_valid, !in_ready)

	`GCM_ASSERT_NEXT(a_report_continues, clk, arst_n, out_valid && out_ready && !out_data.last_row, !in_ready)

	// a vertex never reports itself
	`GCM_ASSERT_NOW(a_zero_diag, clk, arst_n, out_valid, out_data.row_bits[out_data.row_vertex] == 1'b0)

endmodule

bind graph_connectivity_matrix gcm_port_checker u_gcm_checker (.*);

[tb/sv/gcm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcm_checker
// Watches the configuration, request and row channels of the connectivity
// matrix block, keeps its own copy of the graph and vertex count, works out
// the rows each report request must produce and compares every accepted row
// with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module gcm_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [gcm_pkg::VCNT_W-1:0] cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  gcm_pkg::in_item_t          in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  gcm_pkg::out_item_t         out_data,
	output int                         mismatch_count,
	output int                         rows_pending
);

	localparam int NV = gcm_pkg::MAX_VERTICES;
	localparam int VW = gcm_pkg::VIDX_W;

	logic [NV-1:0]              edge_rows [NV];
	logic [gcm_pkg::VCNT_W-1:0] vertex_limit;
	gcm_pkg::out_item_t         pending_rows [$];

	initial begin
		for (int v = 0; v < NV; v++)
			edge_rows[v] = '0;
		vertex_limit   = gcm_pkg::VCOUNT_RESET;
		mismatch_count = 0;
		rows_pending   = 0;
	end

	// counts above the array size saturate
	function automatic int active_vertices();
		return (vertex_limit > NV) ? NV : int'(vertex_limit);
	endfunction

	task automatic store_edge(int a, int b);
		int n;
		n = active_vertices();
		if (a != b && a < n && b < n) begin
			edge_rows[a][b] = 1'b1;
			edge_rows[b][a] = 1'b1;
		end
	endtask

	// reachability per start vertex, only through vertices still in use
	task automatic queue_connectivity_rows();
		int                 n;
		logic [NV-1:0]      in_use;
		logic [NV-1:0]      reach;
		logic [NV-1:0]      prev;
		gcm_pkg::out_item_t row;
		n = active_vertices();
		in_use = '0;
		for (int j = 0; j < n; j++)
			in_use[j] = 1'b1;
		for (int i = 0; i < n; i++) begin
			reach = '0;
			reach[i] = 1'b1;
			do begin
				prev = reach;
				for (int v = 0; v < NV; v++)
					if (prev[v])
						reach = reach | (edge_rows[v] & in_use);
			end while (reach != prev);
			reach[i] = 1'b0;
			row.row_vertex = i[VW-1:0];
			row.row_bits   = reach & in_use;
			row.last_row   = (i == n - 1);
			pending_rows.push_back(row);
		end
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		gcm_pkg::out_item_t want;
		int                 bad;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				vertex_limit = cfg_data;
			if (in_valid && in_ready) begin
				if (in_data.cmd == gcm_pkg::CMD_ADD_EDGE)
					store_edge(int'(in_data.src_vertex), int'(in_data.dst_vertex));
				else
					queue_connectivity_rows();
			end
			if (out_valid && out_ready) begin
				if (pending_rows.size() == 0) begin
					$display("%0t ns: unexpected row, expected none actual vertex %0h bits %h last %b",
						$time, out_data.row_vertex, out_data.row_bits, out_data.last_row);
					mismatch_count++;
				end else begin
					want = pending_rows.pop_front();
					bad = field_differs("row_vertex", 32'(want.row_vertex),
							32'(out_data.row_vertex))
						+ field_differs("row_bits", 32'(want.row_bits),
							32'(out_data.row_bits))
						+ field_differs("last_row", 32'(want.last_row),
							32'(out_data.last_row));
					if (bad != 0)
						mismatch_count++;
				end
			end
			rows_pending = pending_rows.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives edge and report requests and vertex count writes into the
// connectivity matrix block with random gaps and back-pressure; the checker
// beside the block predicts and compares the rows, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NV = gcm_pkg::MAX_VERTICES;
	localparam int VW = gcm_pkg::VIDX_W;
	localparam int CW = gcm_pkg::VCNT_W;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CW-1:0]      cfg_data;
	logic               in_valid;
	logic               in_ready;
	gcm_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	gcm_pkg::out_item_t out_data;

	int mismatch_count;
	int rows_pending;
	bit quiet;
	int cur_count;

	graph_connectivity_matrix i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	gcm_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.rows_pending   (rows_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 26);
	end

	// all drive tasks are entered and left at a falling edge
	task automatic send_request(gcm_pkg::in_item_t item);
		while (!quiet && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_edge(int a, int b);
		gcm_pkg::in_item_t item;
		item.cmd        = gcm_pkg::CMD_ADD_EDGE;
		item.src_vertex = a[VW-1:0];
		item.dst_vertex = b[VW-1:0];
		send_request(item);
	endtask

	// endpoint fields are don't-care on a report, randomize them anyway
	task automatic send_report();
		gcm_pkg::in_item_t item;
		int                a;
		int                b;
		a = $urandom_range(NV - 1);
		b = $urandom_range(NV - 1);
		item.cmd        = gcm_pkg::CMD_REPORT;
		item.src_vertex = a[VW-1:0];
		item.dst_vertex = b[VW-1:0];
		send_request(item);
	endtask

	// register only changes with the block idle: wait until no rows are
	// outstanding, then hold off past the last row before the write
	task automatic write_vertex_count(int v);
		in_valid <= 1'b0;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v[CW-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = (v > NV) ? NV : v;
	endtask

	initial begin
		int counted;
		int a;
		int b;
		int r;
		int blocks;
		int edges;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		quiet     = 1'b0;
		cur_count = NV;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty graph, self-loop, corner vertices
		send_report();
		send_edge(0, 0);
		send_edge(0, 15);
		send_edge(15, 14);
		send_edge(7, 8);
		send_report();
		// lowered count: stored edges to high vertices are masked out
		write_vertex_count(4);
		send_edge(3, 5);
		send_edge(2, 3);
		send_edge(15, 0);
		send_report();
		// zero vertices: nothing stored, nothing reported
		write_vertex_count(0);
		send_edge(1, 2);
		send_report();
		// count above the array saturates
		write_vertex_count(31);
		send_edge(1, 2);
		send_report();
		write_vertex_count(1);
		send_edge(0, 1);
		send_report();
		write_vertex_count(16);
		send_edge(15, 13);
		send_report();

		counted = 0;
		while (counted < 400) begin
			r = $urandom_range(99);
			if (r < 6)
				write_vertex_count(0);
			else if (r < 12)
				write_vertex_count($urandom_range(31, 17));
			else if (r < 20)
				write_vertex_count(16);
			else if (r < 25)
				write_vertex_count(1);
			else
				write_vertex_count($urandom_range(16, 2));
			blocks = $urandom_range(3, 1);
			repeat (blocks) begin
				edges = $urandom_range(4, 0);
				repeat (edges) begin
					quiet = (counted >= 150 && counted < 230);
					if (cur_count >= 2 && $urandom_range(99) < 85) begin
						a = $urandom_range(cur_count - 1);
						b = (a + 1 + $urandom_range(cur_count - 2)) % cur_count;
					end else begin
						// noise: self-loops and endpoints out of use
						a = $urandom_range(NV - 1);
						b = ($urandom_range(1) == 0) ? a : $urandom_range(NV - 1);
					end
					counted++;
					send_edge(a, b);
				end
				send_report();
				counted++;
			end
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (rows_pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && rows_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
